FILE: src/bmp24_to_rgb565_stream_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// bmp24 decoder assertion macros
// shared property wrappers for the decoder checks
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_STREAM_DECODER_CORE_MACROS_SVH
`define BMP24_TO_RGB565_STREAM_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define BMPDEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMPDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bmpdec_pkg.sv
// ----------------------------------------------------------------------------
// bmpdec_pkg
// types and constants shared by the bmp24 to rgb565 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bmpdec_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [14:0] CANVAS_RESET = 15'd240;

  typedef enum logic [1:0] {
    REG_ORIGIN_X      = 2'd0,
    REG_ORIGIN_Y      = 2'd1,
    REG_CANVAS_WIDTH  = 2'd2,
    REG_CANVAS_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_PAD    = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_ORIGIN    = 2'd1,
    ST_SIGNATURE = 2'd2,
    ST_FORMAT    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [14:0]        canvas_width;
    logic [14:0]        canvas_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        pixel_color;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last_pixel;
    status_e            status;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/bmp24_to_rgb565_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_stream_decoder_core
// streaming 24-bit bmp decoder giving rgb565 pixels with canvas coordinates
// ----------------------------------------------------------------------------
// usage:
// - input channel carries one file byte per request; first_byte set on byte 0
//   of a file restarts parsing
// - output channel carries one pixel, or one error report, per request
// - apb port holds origin_x, origin_y, canvas_width, canvas_height at byte
//   addresses 0, 4, 8, 12; write it only while the stream is quiet
// - one byte per cycle sustained while the output is not stalled; a result
//   passes from its last byte through the input register, then the parser
//   state step into the output register
// - the only loop is the parser state update, one byte per clock unless stalled
// - after reset the parser waits for a first_byte; stray bytes are dropped
// - a stall on the output holds the result; one more byte sits in the input
//   register, then in_stall_o rises until the output drains
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp24_to_rgb565_stream_decoder_core_macros.svh"

module bmp24_to_rgb565_stream_decoder_core
  import bmpdec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  in_item_t                   in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_item_q;
  out_item_t res;
  logic      res_valid;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      accept;

  bmpdec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bmpdec_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  `BMPDEC_ASSERT_NOW(a_stall_needs_item, in_stall_o, in_valid_q, "stall with empty input register")
  `BMPDEC_ASSERT_NEXT(a_silent_step, advance && !res_valid, !out_valid_q, "result without cause")
  `BMPDEC_ASSERT_NOW(a_error_zero, out_valid_q && out_item_q.status != ST_PIXEL,
    out_item_q.pixel_color == '0 && !out_item_q.last_pixel, "error report carries pixel data")
  `BMPDEC_ASSERT_NEXT(a_step_loads, advance && res_valid, out_valid_q, "result lost on step")

endmodule

`default_nettype wire

FILE: src/bmpdec_cfg.sv
// ----------------------------------------------------------------------------
// bmpdec_cfg
// apb register bank: canvas origin and canvas size
// ----------------------------------------------------------------------------
`default_nettype none

module bmpdec_cfg
  import bmpdec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_ORIGIN_X:      cfg_d.origin_x      = pwdata[15:0];
        REG_ORIGIN_Y:      cfg_d.origin_y      = pwdata[15:0];
        REG_CANVAS_WIDTH:  cfg_d.canvas_width  = pwdata[14:0];
        REG_CANVAS_HEIGHT: cfg_d.canvas_height = pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_X:      prdata = {16'b0, cfg_q.origin_x};
      REG_ORIGIN_Y:      prdata = {16'b0, cfg_q.origin_y};
      REG_CANVAS_WIDTH:  prdata = {17'b0, cfg_q.canvas_width};
      REG_CANVAS_HEIGHT: prdata = {17'b0, cfg_q.canvas_height};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.canvas_width  <= CANVAS_RESET;
      cfg_q.canvas_height <= CANVAS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmpdec_parser.sv
// ----------------------------------------------------------------------------
// bmpdec_parser
// header parse, offset skip, pixel assembly and row padding skip, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module bmpdec_parser
  import bmpdec_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam logic [5:0]  POS_SIG_END    = 6'd1;
  localparam logic [5:0]  POS_OFFSET_END = 6'd13;
  localparam logic [5:0]  POS_WIDTH_END  = 6'd21;
  localparam logic [5:0]  POS_HEIGHT_END = 6'd25;
  localparam logic [5:0]  POS_PLANES_END = 6'd27;
  localparam logic [5:0]  POS_BPP_END    = 6'd29;
  localparam logic [5:0]  POS_COMP_END   = 6'd33;
  localparam logic [31:0] SIGNATURE      = 32'h0000_4D42;
  localparam logic [31:0] PLANES_OK      = 32'd1;
  localparam logic [31:0] BPP_OK         = 32'd24;
  localparam logic [31:0] HEADER_BYTES   = 32'd34;

  // byte lane of a header position inside its field
  function automatic logic [1:0] field_lane(input logic [5:0] p);
    logic [5:0] s;
    logic [5:0] off;
    if      (p >= 6'd30) s = 6'd30;
    else if (p >= 6'd28) s = 6'd28;
    else if (p >= 6'd26) s = 6'd26;
    else if (p >= 6'd22) s = 6'd22;
    else if (p >= 6'd18) s = 6'd18;
    else if (p >= 6'd14) s = 6'd14;
    else if (p >= 6'd10) s = 6'd10;
    else if (p >= 6'd6)  s = 6'd6;
    else if (p >= 6'd2)  s = 6'd2;
    else                 s = 6'd0;
    off = p - s;
    return off[1:0];
  endfunction

  phase_e      phase_q, phase_d, phase_eff;
  logic [31:0] pos_q, pos_d, pos_eff;
  logic [31:0] field_q, field_d, field_next;
  logic [31:0] offset_q, offset_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] row_q, row_d, row_inc;
  logic [15:0] col_q, col_d, col_inc;
  logic [15:0] row_y_q, row_y_d;
  logic [1:0]  bip_q, bip_d;
  logic [1:0]  pad_q, pad_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;
  logic [5:0]  hp;
  logic [1:0]  lane;
  logic        origin_bad;
  logic [7:0]  b;

  assign b    = item_i.file_byte;
  assign hp   = pos_eff[5:0];
  assign lane = field_lane(hp);

  assign origin_bad =
    ($signed(cfg_i.origin_x) >= $signed({1'b0, cfg_i.canvas_width})) ||
    ($signed(cfg_i.origin_y) >= $signed({1'b0, cfg_i.canvas_height}));

  always_comb begin
    if (lane == 2'd0) begin
      field_next = {24'b0, b};
    end else begin
      field_next = field_q | ({24'b0, b} << {lane, 3'b000});
    end
  end

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    field_d     = field_q;
    offset_d    = offset_q;
    width_d     = width_q;
    height_d    = height_q;
    row_d       = row_q;
    col_d       = col_q;
    row_y_d     = row_y_q;
    bip_d       = bip_q;
    pad_d       = pad_q;
    blue_d      = blue_q;
    green_d     = green_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    phase_eff   = phase_q;
    pos_eff     = pos_q;
    col_inc     = col_q + 16'd1;
    row_inc     = row_q + 16'd1;

    if (item_i.first_byte) begin
      phase_eff = PH_HEADER;
      pos_eff   = '0;
      row_d     = '0;
      col_d     = '0;
      bip_d     = '0;
      pad_d     = '0;
    end

    if (item_i.first_byte && origin_bad) begin
      phase_d      = PH_DONE;
      res_valid_o  = 1'b1;
      res_o.status = ST_ORIGIN;
    end else begin
      unique case (phase_eff)
        PH_HEADER: begin
          phase_d = PH_HEADER;
          field_d = field_next;
          pos_d   = pos_eff + 32'd1;
          if (hp == POS_SIG_END && field_next != SIGNATURE) begin
            phase_d      = PH_DONE;
            res_valid_o  = 1'b1;
            res_o.status = ST_SIGNATURE;
          end
          if (hp == POS_OFFSET_END) offset_d = field_next;
          if (hp == POS_WIDTH_END)  width_d  = field_next[15:0];
          if (hp == POS_HEIGHT_END) height_d = field_next[15:0];
          if ((hp == POS_PLANES_END && field_next != PLANES_OK) ||
              (hp == POS_BPP_END && field_next != BPP_OK)) begin
            phase_d      = PH_DONE;
            res_valid_o  = 1'b1;
            res_o.status = ST_FORMAT;
          end
          if (hp == POS_COMP_END) begin
            if (field_next != '0 || offset_q < HEADER_BYTES) begin
              phase_d      = PH_DONE;
              res_valid_o  = 1'b1;
              res_o.status = ST_FORMAT;
            end else begin
              row_y_d = 16'(cfg_i.origin_y + height_q - 16'd1);
              if (width_q == '0 || height_q == '0) begin
                phase_d = PH_DONE;
              end else if (offset_q == HEADER_BYTES) begin
                phase_d = PH_PIXELS;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          pos_d = pos_q + 32'd1;
          if (pos_d == offset_q) phase_d = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (bip_q == 2'd0) begin
            blue_d = b;
            bip_d  = 2'd1;
          end else if (bip_q == 2'd1) begin
            green_d = b;
            bip_d   = 2'd2;
          end else begin
            res_valid_o       = 1'b1;
            res_o.pixel_color = {b[7:3], green_q[7:2], blue_q[7:3]};
            res_o.pixel_x     = 16'(cfg_i.origin_x + col_q);
            res_o.pixel_y     = row_y_q;
            res_o.status      = ST_PIXEL;
            bip_d             = 2'd0;
            col_d             = col_inc;
            if (col_inc == width_q) begin
              col_d   = '0;
              row_d   = row_inc;
              row_y_d = row_y_q - 16'd1;
              if (row_inc == height_q) begin
                res_o.last_pixel = 1'b1;
                phase_d          = PH_DONE;
              end else if (width_q[1:0] != 2'd0) begin
                // row padding equals width mod 4 for three-byte pixels
                pad_d   = width_q[1:0];
                phase_d = PH_PAD;
              end
            end
          end
        end
        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) phase_d = PH_PIXELS;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      field_q  <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      row_y_q  <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      field_q  <= field_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
      row_y_q  <= row_y_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
    end
  end

endmodule

`default_nettype wire
